// File: design/psg_pkg.sv
// Package for the three-voice sound generator: beat types, codes, tables.
// No dependencies.
`timescale 1ns / 1ps
package psg_pkg;

  localparam int NumVoices = 3;
  localparam int MaxClocks = 7;

  typedef enum logic [2:0] {
    ACT_BYTE_READ  = 3'd0,
    ACT_BYTE_WRITE = 3'd1,
    ACT_WORD_READ  = 3'd2,
    ACT_WORD_WRITE = 3'd3,
    ACT_CLOCK      = 3'd4,
    ACT_NONE5      = 3'd5,
    ACT_NONE6      = 3'd6,
    ACT_NONE7      = 3'd7
  } action_t;

  typedef enum logic [0:0] {
    CFG_BUS_MODE  = 1'b0,
    CFG_TICK_STEP = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TICK,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        address_bit;
    logic [15:0] write_data;
    logic [2:0]  clock_count;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [11:0] mix_level;
    logic [7:0]  port_a_value;
    logic [7:0]  port_b_value;
    logic [3:0]  envelope_level;
  } out_beat_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic        do_read;
    logic        word_read;
    logic        abit;
    logic        do_select;
    logic [3:0]  select_value;
    logic        do_write;
    logic [7:0]  write_value;
    logic        use_select;
    logic        do_clock;
    logic [2:0]  clocks;
    logic        ff_read;
  } cmd_t;

  function automatic logic [9:0] dac_level(input logic [3:0] s);
    logic [9:0] v;
    unique case (s)
      4'd0: v = 10'd0;     4'd1: v = 10'd14;   4'd2: v = 10'd21;   4'd3: v = 10'd29;
      4'd4: v = 10'd42;    4'd5: v = 10'd62;   4'd6: v = 10'd85;   4'd7: v = 10'd137;
      4'd8: v = 10'd169;   4'd9: v = 10'd265;  4'd10: v = 10'd353; 4'd11: v = 10'd450;
      4'd12: v = 10'd570;  4'd13: v = 10'd728; 4'd14: v = 10'd869; default: v = 10'd1000;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] reg_mask(input logic [3:0] r);
    logic [7:0] m;
    unique case (r)
      4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
      4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// File: design/psg_front.sv
// Front part: accepts input beats, decodes the bus protocol, feeds a two-entry queue.
// Depends on psg_pkg.
`timescale 1ns / 1ps
module psg_front import psg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     bus_mode,
  input  in_beat_t in_beat,
  input  logic     in_valid,
  output logic     in_ready,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_ready
);

  cmd_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  cmd_t dec;
  logic push, pop;

  always_comb begin
    dec = '0;
    dec.abit = in_beat.address_bit;
    dec.clocks = (in_beat.clock_count > 3'(MaxClocks)) ? 3'(MaxClocks) : in_beat.clock_count;
    unique case (action_t'(in_beat.action))
      ACT_BYTE_READ: begin
        dec.do_read = 1'b1;
        dec.ff_read = bus_mode;
      end
      ACT_WORD_READ: begin
        dec.do_read = 1'b1;
        dec.word_read = 1'b1;
        dec.ff_read = bus_mode;
      end
      ACT_BYTE_WRITE: begin
        if (bus_mode) begin
          dec.do_write = !in_beat.address_bit;
          dec.write_value = ~in_beat.write_data[7:0];
        end else if (in_beat.address_bit) begin
          dec.do_write = 1'b1;
          dec.write_value = in_beat.write_data[7:0];
        end else begin
          dec.do_select = 1'b1;
          dec.select_value = in_beat.write_data[3:0];
        end
      end
      ACT_WORD_WRITE: begin
        dec.do_select = 1'b1;
        if (bus_mode) begin
          dec.select_value = ~in_beat.write_data[3:0];
        end else begin
          dec.select_value = in_beat.write_data[3:0];
          dec.do_write = 1'b1;
          dec.write_value = in_beat.write_data[15:8];
          dec.use_select = 1'b1;
        end
      end
      ACT_CLOCK: dec.do_clock = 1'b1;
      default: ;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) q[wr_ptr] <= dec;
  end

endmodule

// File: design/psg_back.sv
// Back part: register file, tone/noise/envelope generators, mixer and output register.
// Depends on psg_pkg.
`timescale 1ns / 1ps
module psg_back import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] tick_step,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  output out_beat_t   out_beat,
  output logic        out_valid,
  input  logic        out_ready
);

  back_state_t state, state_next;
  logic [7:0]  regs [16];
  logic [3:0]  sel;
  logic [15:0] phase;
  logic [19:0] phase_sum;
  logic [3:0]  ticks;
  logic [11:0] tcnt [NumVoices];
  logic [NumVoices-1:0] tout;
  logic        half;
  logic [4:0]  ncnt;
  logic [16:0] lfsr;
  logic [15:0] ecnt;
  logic [3:0]  estep, eatt, evol;
  logic        ehold, ealt, eholding;
  logic [15:0] rd_hold;
  logic        take, do_tick, reg_wr, emit;
  logic [3:0]  wr_idx;
  logic [7:0]  shape;
  logic [15:0] eper;
  logic [7:0]  nper;
  logic [13:0] mix_sum;

  assign take = (state == BK_IDLE) && cmd_valid;
  assign cmd_ready = (state == BK_IDLE);
  assign phase_sum = {4'd0, phase} + 20'(cmd.clocks) * 20'(tick_step);
  assign do_tick = (state == BK_TICK) && (ticks != 4'd0);
  assign emit = (state == BK_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (cmd_valid) state_next = cmd.do_clock ? BK_TICK : BK_OUT;
      BK_TICK: if (ticks <= 4'd1) state_next = BK_OUT;
      BK_OUT:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign reg_wr = take && cmd.do_write;
  assign wr_idx = cmd.use_select ? cmd.select_value : sel;
  assign shape = cmd.write_value & reg_mask(wr_idx);
  assign eper = ({regs[12], regs[11]} == 16'd0) ? 16'd1 : {regs[12], regs[11]};
  assign nper = (regs[6] == 8'd0) ? 8'd1 : regs[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      sel <= '0;
      phase <= '0;
      ticks <= '0;
      for (int i = 0; i < NumVoices; i++) tcnt[i] <= '0;
      tout <= '0;
      half <= 1'b0;
      ncnt <= '0;
      lfsr <= 17'd1;
      ecnt <= '0;
      estep <= 4'd15;
      eatt <= 4'd0;
      ehold <= 1'b1;
      ealt <= 1'b0;
      eholding <= 1'b0;
      evol <= 4'd15;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (take) begin
        if (cmd.do_select) sel <= cmd.select_value;
        if (cmd.do_clock) begin
          phase <= phase_sum[15:0];
          ticks <= phase_sum[19:16];
        end
        if (reg_wr) begin
          regs[wr_idx] <= shape;
          if (wr_idx == 4'd13) begin
            eatt <= shape[2] ? 4'hF : 4'h0;
            ehold <= shape[3] ? shape[0] : 1'b1;
            ealt <= shape[3] ? shape[1] : shape[2];
            ecnt <= '0;
            estep <= 4'd15;
            eholding <= 1'b0;
            evol <= shape[2] ? 4'h0 : 4'hF;
          end
        end
      end
      if (do_tick) begin
        ticks <= ticks - 4'd1;
        for (int c = 0; c < NumVoices; c++) begin
          if ({4'd0, tcnt[c]} + 16'd1 >=
              (({regs[4'(2*c+1)], regs[4'(2*c)]} == 16'd0) ? 16'd1
              : {regs[4'(2*c+1)], regs[4'(2*c)]})) begin
            tcnt[c] <= '0;
            tout[c] <= !tout[c];
          end else begin
            tcnt[c] <= tcnt[c] + 12'd1;
          end
        end
        half <= !half;
        if (half) begin
          if ({3'd0, ncnt} + 8'd1 >= nper) begin
            ncnt <= '0;
            lfsr <= {lfsr[0] ^ lfsr[3], lfsr[16:1]};
          end else begin
            ncnt <= ncnt + 5'd1;
          end
          if (!eholding) begin
            if ({1'b0, ecnt} + 17'd1 >= {1'b0, eper}) begin
              ecnt <= '0;
              if (estep == 4'd0) begin
                if (ehold) begin
                  eholding <= 1'b1;
                  evol <= ealt ? ~eatt : eatt;
                end else begin
                  estep <= 4'd15;
                  evol <= 4'hF ^ (ealt ? ~eatt : eatt);
                end
                if (ealt) eatt <= ~eatt;
              end else begin
                estep <= estep - 4'd1;
                evol <= (estep - 4'd1) ^ eatt;
              end
            end else begin
              ecnt <= ecnt + 16'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!cmd.do_read) rd_hold <= '0;
      else if (cmd.ff_read) rd_hold <= cmd.word_read ? 16'hFFFF : 16'h00FF;
      else if (cmd.word_read) rd_hold <= {regs[sel], 4'd0, sel};
      else rd_hold <= cmd.abit ? {8'd0, regs[sel]} : {12'd0, sel};
    end
  end

  always_comb begin
    mix_sum = '0;
    for (int c = 0; c < NumVoices; c++) begin
      if ((tout[c] | regs[7][c]) && (lfsr[0] | regs[7][c+3])) begin
        mix_sum = mix_sum +
                  14'(dac_level(regs[4'(8+c)][4] ? evol : regs[4'(8+c)][3:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat.read_data <= rd_hold;
      out_beat.mix_level <= (mix_sum > 14'd4095) ? 12'd4095 : mix_sum[11:0];
      out_beat.port_a_value <= regs[14];
      out_beat.port_b_value <= regs[15];
      out_beat.envelope_level <= evol;
    end
  end

endmodule

// File: design/psg_three_voice_sound_generator.sv
// Top level of the three-voice sound generator: configuration registers and wiring.
// Depends on psg_pkg, psg_front and psg_back.
// Usage:
// The input channel carries bus reads, bus writes and clock advance beats; every
// input beat yields exactly one output beat with read data, mix level, both port
// registers and the envelope level after the beat.
// The front part decodes the bus protocol and queues up to two commands, so it
// keeps accepting while the back part works or its output waits.
// A bus beat passes from the back part's idle state to its output state; a clock beat
// goes through the tick state first, at one tone tick per cycle (7 ticks at a step of
// 1.0; the largest step gives up to 14 ticks), and passes through it even with no tick.
// The tick loop in the back part sets the throughput; out_valid is registered and rises
// once the command has reached the back part's output state.
// Configuration: cfg_write with cfg_index 0 sets bus_mode, 1 sets tick_step.
// Reset clears the sixteen sound registers, loads the noise shift register with one and the
// envelope volume with fifteen. A stalled receiver holds the output beat; the
// back part then waits and the queue fills before in_ready drops.
`timescale 1ns / 1ps
module psg_three_voice_sound_generator import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  in_beat_t    in_beat,
  input  logic        in_valid,
  output logic        in_ready,
  output out_beat_t   out_beat,
  output logic        out_valid,
  input  logic        out_ready
);

  logic        bus_mode;
  logic [16:0] tick_step;
  cmd_t        cmd;
  logic        cmd_valid, cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b0;
      tick_step <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BUS_MODE:  bus_mode <= cfg_data[0];
        CFG_TICK_STEP: tick_step <= cfg_data;
        default: ;
      endcase
    end
  end

  psg_front u_front (
    .clk(clk), .rst(rst), .bus_mode(bus_mode),
    .in_beat(in_beat), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  psg_back u_back (
    .clk(clk), .rst(rst), .tick_step(tick_step),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .out_beat(out_beat), .out_valid(out_valid), .out_ready(out_ready)
  );

endmodule
